// ===== rtl/core/fsm_pkg.sv =====
// Package for the Forth stack machine core: cell width, depths, opcodes,
// error codes, stack commands and the sequencer state type. No dependencies.
`default_nettype none
package fsm_pkg;
    localparam int CELL_BITS    = 32;
    localparam int DATA_DEPTH   = 64;
    localparam int RETURN_DEPTH = 32;
    localparam int MEM_WORDS    = 1024;
    localparam int DCNT_BITS    = $clog2(DATA_DEPTH + 1);
    localparam int RCNT_BITS    = $clog2(RETURN_DEPTH + 1);
    localparam int ADDR_BITS    = $clog2(MEM_WORDS);
    localparam int DIV_CBITS    = $clog2(CELL_BITS + 1);

    typedef logic [CELL_BITS-1:0] cell_t;

    typedef enum logic [4:0] {
        OP_LIT = 5'd0, OP_ADD = 5'd1, OP_SUB = 5'd2, OP_MUL = 5'd3, OP_DIV = 5'd4,
        OP_MOD = 5'd5, OP_AND = 5'd6, OP_OR = 5'd7, OP_XOR = 5'd8, OP_SHL = 5'd9,
        OP_SHR = 5'd10, OP_LT = 5'd11, OP_ULT = 5'd12, OP_EQ = 5'd13, OP_DUP = 5'd14,
        OP_SWAP = 5'd15, OP_DROP = 5'd16, OP_TOR = 5'd17, OP_FROMR = 5'd18,
        OP_FETCH = 5'd19, OP_STORE = 5'd20, OP_DEPTH = 5'd21, OP_BASE = 5'd22
    } opcode_t;

    typedef enum logic [2:0] {
        ERR_OK = 3'd0, ERR_DUNDER = 3'd1, ERR_DOVER = 3'd2, ERR_RUNDER = 3'd3,
        ERR_ROVER = 3'd4, ERR_DIVZ = 3'd5, ERR_ADDR = 3'd6
    } err_t;

    // Stack cell row command: on push and pop the cells shift together, load writes the top cells.
    typedef enum logic [1:0] {
        SC_HOLD = 2'd0, SC_PUSH = 2'd1, SC_POP = 2'd2, SC_LOAD = 2'd3
    } scmd_t;

    typedef struct packed {
        scmd_t cmd;
        logic  wr0;
        logic  wr1;
        cell_t d0;
        cell_t d1;
    } stk_ctl_t;

    typedef enum logic [2:0] {
        ST_IDLE, ST_DIV, ST_MEMRD, ST_CLEAR, ST_OUT
    } state_t;
endpackage
`default_nettype wire

// ===== rtl/core/fsm_if.sv =====
// Valid/ready channel interfaces for input and result items.
// No dependencies.
`default_nettype none
interface fsm_in_if (input wire logic clk);
    logic              valid;
    logic              ready;
    logic [4:0]        opcode;
    logic signed [31:0] literal;
    modport source (output valid, opcode, literal, input ready);
    modport sink (input valid, opcode, literal, output ready);
endinterface

interface fsm_out_if (input wire logic clk);
    logic               valid;
    logic               ready;
    logic signed [31:0] top_value;
    logic [6:0]         data_depth;
    logic [5:0]         return_depth;
    logic [2:0]         error_code;
    modport source (output valid, top_value, data_depth, return_depth, error_code,
                    input ready);
    modport sink (input valid, top_value, data_depth, return_depth, error_code,
                  output ready);
endinterface
`default_nettype wire

// ===== rtl/core/forth_stack_machine_core.sv =====
// Top level of the Forth stack machine core.
// Depends on fsm_pkg, fsm_if, fsm_stack, fsm_div.
// An item goes through execute, then the result register; store adds its second
// pop in the result state, fetch adds the memory read state, and div and mod
// go through the bit-serial divider (start, 32 steps, done, result).
// After reset a clearing pass zeroes the data memory, during which no item
// is accepted. Both stacks are rows of cells that shift on push and pop.
`default_nettype none
module forth_stack_machine_core (
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    cfg_we,
    input  wire logic [5:0] cfg_wdata,
    fsm_in_if.sink       in_ch,
    fsm_out_if.source    out_ch
);
    import fsm_pkg::*;

    state_t state_reg, state_next;
    logic [DCNT_BITS-1:0] dcnt_reg, dcnt_next;
    logic [RCNT_BITS-1:0] rcnt_reg, rcnt_next;
    logic [5:0] base_reg;
    logic [ADDR_BITS:0] clr_reg;
    logic [4:0] op_reg;
    logic [2:0] err_reg, err_c;
    cell_t mem [MEM_WORDS];
    cell_t rd_reg;
    cell_t dtos, dnos, rtos, quo, rem;
    stk_ctl_t dctl, rctl;
    stk_ctl_t dctl_f;
    logic pop2_reg;
    logic div_start, div_done, acc;
    logic mem_we;
    cell_t res;

    assign acc = in_ch.valid && in_ch.ready;
    assign in_ch.ready = state_reg == ST_IDLE;

    fsm_stack #(.DEPTH(DATA_DEPTH)) u_dstk (.clk(clk), .ctl(dctl_f), .tos(dtos), .nos(dnos));
    fsm_stack #(.DEPTH(RETURN_DEPTH)) u_rstk (.clk(clk), .ctl(rctl), .tos(rtos), .nos());
    fsm_div u_div (.clk(clk), .rst_n(rst_n), .start(div_start), .a(dnos), .b(dtos),
                   .done(div_done), .quo(quo), .rem(rem));

    logic d_lt1, d_lt2, d_full, r_lt1, r_full, bad_addr;
    always_comb
    begin
        d_lt1    = dcnt_reg < DCNT_BITS'(1);
        d_lt2    = dcnt_reg < DCNT_BITS'(2);
        d_full   = dcnt_reg >= DCNT_BITS'(DATA_DEPTH);
        r_lt1    = rcnt_reg == '0;
        r_full   = rcnt_reg >= RCNT_BITS'(RETURN_DEPTH);
        bad_addr = dtos >= cell_t'(MEM_WORDS);
    end

    // error check on the incoming opcode
    always_comb
    begin
        err_c = ERR_OK;
        case (in_ch.opcode) inside
            [OP_ADD:OP_EQ]:
                if (d_lt2) err_c = ERR_DUNDER;
                else if ((in_ch.opcode == OP_DIV || in_ch.opcode == OP_MOD) && dtos == '0)
                    err_c = ERR_DIVZ;
            OP_LIT, OP_DEPTH, OP_BASE: if (d_full) err_c = ERR_DOVER;
            OP_DUP: if (d_lt1) err_c = ERR_DUNDER; else if (d_full) err_c = ERR_DOVER;
            OP_SWAP: if (d_lt2) err_c = ERR_DUNDER;
            OP_DROP: if (d_lt1) err_c = ERR_DUNDER;
            OP_TOR: if (d_lt1) err_c = ERR_DUNDER; else if (r_full) err_c = ERR_ROVER;
            OP_FROMR: if (r_lt1) err_c = ERR_RUNDER; else if (d_full) err_c = ERR_DOVER;
            OP_FETCH: if (d_lt1) err_c = ERR_DUNDER; else if (bad_addr) err_c = ERR_ADDR;
            OP_STORE: if (d_lt2) err_c = ERR_DUNDER; else if (bad_addr) err_c = ERR_ADDR;
            default: err_c = ERR_OK;
        endcase
    end

    always_comb
    begin
        logic [CELL_BITS-1:0] sh;
        logic big;
        big = dtos >= cell_t'(CELL_BITS);
        sh  = cell_t'(dtos[DIV_CBITS-1:0]);
        case (in_ch.opcode)
            OP_ADD: res = dnos + dtos;
            OP_SUB: res = dnos - dtos;
            OP_MUL: res = dnos * dtos;
            OP_AND: res = dnos & dtos;
            OP_OR:  res = dnos | dtos;
            OP_XOR: res = dnos ^ dtos;
            OP_SHL: res = big ? '0 : dnos << sh;
            OP_SHR: res = big ? '0 : dnos >> sh;
            OP_LT:  res = {CELL_BITS{$signed(dnos) < $signed(dtos)}};
            OP_ULT: res = {CELL_BITS{dnos < dtos}};
            default: res = {CELL_BITS{dnos == dtos}};
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR: if (clr_reg == (ADDR_BITS+1)'(MEM_WORDS - 1)) state_next = ST_IDLE;
            ST_IDLE:
                if (acc)
                begin
                    if (err_c == ERR_OK &&
                        (in_ch.opcode == OP_DIV || in_ch.opcode == OP_MOD))
                        state_next = ST_DIV;
                    else if (err_c == ERR_OK && in_ch.opcode == OP_FETCH)
                        state_next = ST_MEMRD;
                    else state_next = ST_OUT;
                end
            ST_DIV:   if (div_done) state_next = ST_OUT;
            ST_MEMRD: state_next = ST_OUT;
            ST_OUT:   if (out_ch.valid && out_ch.ready) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        dctl = '{cmd: SC_HOLD, wr0: 1'b0, wr1: 1'b0, d0: '0, d1: '0};
        rctl = '{cmd: SC_HOLD, wr0: 1'b0, wr1: 1'b0, d0: dtos, d1: '0};
        dcnt_next = dcnt_reg;
        rcnt_next = rcnt_reg;
        div_start = 1'b0;
        mem_we = 1'b0;
        if (state_reg == ST_DIV && div_done)
        begin
            dctl = '{cmd: SC_POP, wr0: 1'b0, wr1: 1'b1, d0: '0,
                     d1: (op_reg == OP_DIV) ? quo : rem};
            dcnt_next = dcnt_reg - 1'b1;
        end
        else if (state_reg == ST_MEMRD)
            dctl = '{cmd: SC_LOAD, wr0: 1'b1, wr1: 1'b0, d0: rd_reg, d1: '0};
        else if (acc && err_c == ERR_OK)
        begin
            case (in_ch.opcode) inside
                OP_DIV, OP_MOD: div_start = 1'b1;
                [OP_ADD:OP_EQ]:
                begin
                    dctl = '{cmd: SC_POP, wr0: 1'b0, wr1: 1'b1, d0: '0, d1: res};
                    dcnt_next = dcnt_reg - 1'b1;
                end
                OP_LIT, OP_DEPTH, OP_BASE, OP_DUP, OP_FROMR:
                begin
                    dctl.cmd = SC_PUSH;
                    case (in_ch.opcode)
                        OP_LIT:   dctl.d0 = cell_t'(in_ch.literal);
                        OP_DEPTH: dctl.d0 = cell_t'(dcnt_reg);
                        OP_BASE:  dctl.d0 = cell_t'(base_reg);
                        OP_DUP:   dctl.d0 = dtos;
                        default:  dctl.d0 = rtos;
                    endcase
                    dcnt_next = dcnt_reg + 1'b1;
                    if (in_ch.opcode == OP_FROMR)
                    begin
                        rctl.cmd = SC_POP;
                        rcnt_next = rcnt_reg - 1'b1;
                    end
                end
                OP_SWAP: dctl = '{cmd: SC_LOAD, wr0: 1'b1, wr1: 1'b1, d0: dnos, d1: dtos};
                OP_DROP:
                begin
                    dctl.cmd = SC_POP;
                    dcnt_next = dcnt_reg - 1'b1;
                end
                OP_TOR:
                begin
                    dctl.cmd = SC_POP;
                    dcnt_next = dcnt_reg - 1'b1;
                    rctl.cmd = SC_PUSH;
                    rcnt_next = rcnt_reg + 1'b1;
                end
                OP_STORE:
                begin
                    mem_we = 1'b1;
                    dctl.cmd = SC_POP;
                    dcnt_next = dcnt_reg - DCNT_BITS'(2);
                end
                default: ;
            endcase
        end
    end

    // store drops two: second pop in the result cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            dcnt_reg  <= '0;
            rcnt_reg  <= '0;
            base_reg  <= 6'd10;
            clr_reg   <= '0;
            pop2_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            dcnt_reg  <= dcnt_next;
            rcnt_reg  <= rcnt_next;
            pop2_reg  <= mem_we;
            if (cfg_we) base_reg <= cfg_wdata;
            if (state_reg == ST_CLEAR) clr_reg <= clr_reg + 1'b1;
        end
    end

    always_comb
    begin
        dctl_f = dctl;
        if (pop2_reg) dctl_f.cmd = SC_POP;
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_CLEAR) mem[clr_reg[ADDR_BITS-1:0]] <= '0;
        else if (mem_we) mem[dtos[ADDR_BITS-1:0]] <= dnos;
        rd_reg <= mem[dtos[ADDR_BITS-1:0]];
        if (acc)
        begin
            op_reg  <= in_ch.opcode;
            err_reg <= err_c;
        end
    end

    assign out_ch.valid        = state_reg == ST_OUT && !pop2_reg;
    assign out_ch.top_value    = (dcnt_reg == '0) ? '0 : dtos;
    assign out_ch.data_depth   = dcnt_reg;
    assign out_ch.return_depth = rcnt_reg;
    assign out_ch.error_code   = err_reg;

`ifndef SYNTH
    a_full: assert property (@(posedge clk) disable iff (!rst_n)
        dcnt_reg <= DCNT_BITS'(DATA_DEPTH)) else $error("data depth");
    a_rfull: assert property (@(posedge clk) disable iff (!rst_n)
        rcnt_reg <= RCNT_BITS'(RETURN_DEPTH)) else $error("return depth");
    a_noacc: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_CLEAR |-> !in_ch.ready) else $error("accept during clear");
`endif
endmodule
`default_nettype wire

// ===== rtl/core/fsm_cell.sv =====
// One stack cell: holds one entry, takes from its upper or lower neighbor or loads a value.
// Depends on fsm_pkg.
`default_nettype none
module fsm_cell (
    input  wire logic          clk,
    input  wire fsm_pkg::scmd_t cmd,
    input  wire fsm_pkg::cell_t from_up,
    input  wire fsm_pkg::cell_t from_down,
    input  wire fsm_pkg::cell_t load,
    output fsm_pkg::cell_t      q
);
    import fsm_pkg::*;
    cell_t q_reg;
    always_ff @(posedge clk)
    begin
        case (cmd)
            SC_PUSH: q_reg <= from_up;
            SC_POP:  q_reg <= from_down;
            SC_LOAD: q_reg <= load;
            default: q_reg <= q_reg;
        endcase
    end
    assign q = q_reg;
endmodule
`default_nettype wire

// ===== rtl/core/fsm_stack.sv =====
// Stack as a row of cells; cell 0 is the top. Depends on fsm_pkg, fsm_cell.
`default_nettype none
module fsm_stack #(
    parameter int DEPTH = 64
) (
    input  wire logic             clk,
    input  wire fsm_pkg::stk_ctl_t ctl,
    output fsm_pkg::cell_t        tos,
    output fsm_pkg::cell_t        nos
);
    import fsm_pkg::*;
    cell_t q [DEPTH];
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        cell_t up, down, ld;
        scmd_t c;
        always_comb
        begin
            up   = (i == 0) ? ctl.d0 : q[(i == 0) ? 0 : i-1];
            down = (i == DEPTH-1) ? q[i] : q[(i == DEPTH-1) ? i : i+1];
            ld   = (i == 0) ? ctl.d0 : ctl.d1;
            c    = ctl.cmd;
            if (ctl.cmd == SC_LOAD)
                c = ((i == 0 && ctl.wr0) || (i == 1 && ctl.wr1)) ? SC_LOAD : SC_HOLD;
            if (ctl.cmd == SC_POP && i == 0 && ctl.wr0)
                c = SC_LOAD;
            if (ctl.cmd == SC_POP && i == 0 && ctl.wr1)
                c = SC_LOAD;
        end
        fsm_cell u_cell (.clk(clk), .cmd(c), .from_up(up), .from_down(down),
                         .load(ctl.wr1 && ctl.cmd == SC_POP ? ctl.d1 : ld), .q(q[i]));
    end
    assign tos = q[0];
    assign nos = q[1];
endmodule
`default_nettype wire

// ===== rtl/core/fsm_div.sv =====
// Restoring divider, one quotient bit per cycle, signed truncating results.
// Depends on fsm_pkg.
`default_nettype none
module fsm_div (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    input  wire fsm_pkg::cell_t a,
    input  wire fsm_pkg::cell_t b,
    output logic               done,
    output fsm_pkg::cell_t     quo,
    output fsm_pkg::cell_t     rem
);
    import fsm_pkg::*;
    cell_t rem_reg, quo_reg, div_reg;
    logic neg_q_reg, neg_r_reg, busy_reg, done_reg;
    logic [DIV_CBITS-1:0] cnt_reg;
    logic [CELL_BITS:0] trial;
    always_comb trial = {rem_reg, quo_reg[CELL_BITS-1]} - {1'b0, div_reg};
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && !start && cnt_reg == DIV_CBITS'(1);
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= DIV_CBITS'(CELL_BITS);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == DIV_CBITS'(1))
                    busy_reg <= 1'b0;
            end
        end
    end
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg   <= '0;
            quo_reg   <= a[CELL_BITS-1] ? -a : a;
            div_reg   <= b[CELL_BITS-1] ? -b : b;
            neg_q_reg <= a[CELL_BITS-1] ^ b[CELL_BITS-1];
            neg_r_reg <= a[CELL_BITS-1];
        end
        else if (busy_reg)
        begin
            if (!trial[CELL_BITS])
            begin
                rem_reg <= trial[CELL_BITS-1:0];
                quo_reg <= {quo_reg[CELL_BITS-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= {rem_reg[CELL_BITS-2:0], quo_reg[CELL_BITS-1]};
                quo_reg <= {quo_reg[CELL_BITS-2:0], 1'b0};
            end
        end
    end
    assign done = done_reg;
    assign quo  = neg_q_reg ? -quo_reg : quo_reg;
    assign rem  = neg_r_reg ? -rem_reg : rem_reg;
endmodule
`default_nettype wire

// ===== dv/tb_top.sv =====
// Self-checking testbench for forth_stack_machine_core: a clocked driver feeds
// primitives from a queue, a monitor compares each result with a local model.
// Depends on fsm_pkg and the fsm_in_if / fsm_out_if interfaces.
`timescale 1ns / 100ps
`default_nettype none
module tb_top;
    import fsm_pkg::*;

    typedef struct packed {
        logic [4:0]  opcode;
        logic [31:0] literal;
    } prim_t;

    typedef struct packed {
        logic [31:0] top_value;
        logic [6:0]  data_depth;
        logic [5:0]  return_depth;
        logic [2:0]  error_code;
    } status_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [5:0] cfg_wdata;

    fsm_in_if  in_ch (clk);
    fsm_out_if out_ch (clk);

    forth_stack_machine_core dut (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .in_ch(in_ch), .out_ch(out_ch)
    );

    // local model state
    logic [31:0] m_dstk [DATA_DEPTH];
    logic [31:0] m_rstk [RETURN_DEPTH];
    logic [31:0] m_mem  [MEM_WORDS] = '{default: '0};
    int unsigned m_dcnt = 0;
    int unsigned m_rcnt = 0;
    logic [5:0]  m_base;

    prim_t   pending_prims [$];
    status_t expected_status [$];
    int unsigned mismatches = 0;
    int unsigned cycles = 0;
    int unsigned drv_wait, mon_wait;
    logic        in_taken;

    function automatic logic [31:0] sdiv(logic [31:0] a, logic [31:0] b, bit want_rem);
        logic [31:0] ua, ub, q, r;
        ua = a[31] ? -a : a;
        ub = b[31] ? -b : b;
        q = ua / ub;
        r = ua % ub;
        if (want_rem) return a[31] ? -r : r;
        return (a[31] != b[31]) ? -q : q;
    endfunction

    function automatic err_t run_prim(prim_t p);
        int unsigned n;
        logic [31:0] a, b, v;
        n = m_dcnt;
        if (p.opcode >= OP_ADD && p.opcode <= OP_EQ) begin
            if (n < 2) return ERR_DUNDER;
            a = m_dstk[n-2];
            b = m_dstk[n-1];
            if ((p.opcode == OP_DIV || p.opcode == OP_MOD) && b == 0) return ERR_DIVZ;
            case (opcode_t'(p.opcode))
                OP_ADD: v = a + b;
                OP_SUB: v = a - b;
                OP_MUL: v = a * b;
                OP_DIV: v = sdiv(a, b, 0);
                OP_MOD: v = sdiv(a, b, 1);
                OP_AND: v = a & b;
                OP_OR:  v = a | b;
                OP_XOR: v = a ^ b;
                OP_SHL: v = (b >= CELL_BITS) ? 32'd0 : a << b[5:0];
                OP_SHR: v = (b >= CELL_BITS) ? 32'd0 : a >> b[5:0];
                OP_LT:  v = ($signed(a) < $signed(b)) ? '1 : '0;
                OP_ULT: v = (a < b) ? '1 : '0;
                default: v = (a == b) ? '1 : '0;
            endcase
            m_dstk[n-2] = v;
            m_dcnt = n - 1;
            return ERR_OK;
        end
        case (opcode_t'(p.opcode))
            OP_LIT, OP_DEPTH, OP_BASE:
            begin
                if (n >= DATA_DEPTH) return ERR_DOVER;
                if (p.opcode == OP_LIT) m_dstk[n] = p.literal;
                else if (p.opcode == OP_DEPTH) m_dstk[n] = n;
                else m_dstk[n] = {26'd0, m_base};
                m_dcnt = n + 1;
            end
            OP_DUP:
            begin
                if (n < 1) return ERR_DUNDER;
                if (n >= DATA_DEPTH) return ERR_DOVER;
                m_dstk[n] = m_dstk[n-1];
                m_dcnt = n + 1;
            end
            OP_SWAP:
            begin
                if (n < 2) return ERR_DUNDER;
                a = m_dstk[n-1];
                m_dstk[n-1] = m_dstk[n-2];
                m_dstk[n-2] = a;
            end
            OP_DROP:
            begin
                if (n < 1) return ERR_DUNDER;
                m_dcnt = n - 1;
            end
            OP_TOR:
            begin
                if (n < 1) return ERR_DUNDER;
                if (m_rcnt >= RETURN_DEPTH) return ERR_ROVER;
                m_rstk[m_rcnt] = m_dstk[n-1];
                m_rcnt++;
                m_dcnt = n - 1;
            end
            OP_FROMR:
            begin
                if (m_rcnt < 1) return ERR_RUNDER;
                if (n >= DATA_DEPTH) return ERR_DOVER;
                m_dstk[n] = m_rstk[m_rcnt-1];
                m_rcnt--;
                m_dcnt = n + 1;
            end
            OP_FETCH:
            begin
                if (n < 1) return ERR_DUNDER;
                a = m_dstk[n-1];
                if (a >= MEM_WORDS) return ERR_ADDR;
                m_dstk[n-1] = m_mem[a];
            end
            OP_STORE:
            begin
                if (n < 2) return ERR_DUNDER;
                a = m_dstk[n-1];
                if (a >= MEM_WORDS) return ERR_ADDR;
                m_mem[a] = m_dstk[n-2];
                m_dcnt = n - 2;
            end
            default: ;
        endcase
        return ERR_OK;
    endfunction

    task automatic predict_status(prim_t p);
        status_t s;
        err_t e;
        e = run_prim(p);
        s.top_value = (m_dcnt > 0) ? m_dstk[m_dcnt-1] : 32'd0;
        s.data_depth = 7'(m_dcnt);
        s.return_depth = 6'(m_rcnt);
        s.error_code = e;
        expected_status.push_back(s);
    endtask

    task automatic queue_prim(logic [4:0] op, logic [31:0] lit);
        prim_t p;
        p.opcode = op;
        p.literal = lit;
        pending_prims.push_back(p);
    endtask

    function automatic logic [31:0] rand_cell();
        case ($urandom_range(0, 7))
            0: return 32'd0;
            1: return 32'hFFFF_FFFF;
            2: return 32'h8000_0000;
            3: return 32'h7FFF_FFFF;
            4: return $urandom_range(0, 40);
            5: return $urandom_range(0, MEM_WORDS + 8);
            default: return $urandom;
        endcase
    endfunction

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // driver
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_ch.valid <= 1'b0;
            in_ch.opcode <= '0;
            in_ch.literal <= '0;
            drv_wait <= $urandom_range(0, 18);
        end
        else if (in_ch.valid && !in_taken)
        begin
        end
        else if (drv_wait != 0)
        begin
            in_ch.valid <= 1'b0;
            drv_wait <= drv_wait - 1;
        end
        else if (pending_prims.size() != 0)
        begin
            prim_t p;
            p = pending_prims.pop_front();
            in_ch.valid <= 1'b1;
            in_ch.opcode <= p.opcode;
            in_ch.literal <= p.literal;
            drv_wait <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18);
        end
        else
            in_ch.valid <= 1'b0;
    end

    // accept on the rising edge: predict from the item seen at the handshake
    always @(posedge clk)
    begin
        if (rst_n && in_ch.valid && in_ch.ready)
        begin
            prim_t p;
            p.opcode = in_ch.opcode;
            p.literal = in_ch.literal;
            predict_status(p);
            in_taken <= 1'b1;
        end
        else
            in_taken <= 1'b0;
    end

    // result ready with random stalls
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ch.ready <= 1'b0;
            mon_wait <= 0;
        end
        else if (out_ch.ready && out_ch.valid)
        begin
            out_ch.ready <= 1'b0;
            mon_wait <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18);
        end
        else if (mon_wait != 0)
        begin
            out_ch.ready <= 1'b0;
            mon_wait <= mon_wait - 1;
        end
        else
            out_ch.ready <= 1'b1;
    end

    // monitor
    always @(posedge clk)
    begin
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            status_t s, got;
            got.top_value = out_ch.top_value;
            got.data_depth = out_ch.data_depth;
            got.return_depth = out_ch.return_depth;
            got.error_code = out_ch.error_code;
            if (expected_status.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result top=%h dd=%0d rd=%0d err=%0d",
                             got.top_value, got.data_depth, got.return_depth,
                             got.error_code);
            end
            else
            begin
                s = expected_status.pop_front();
                if (s != got)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"mismatch exp top=%h dd=%0d rd=%0d err=%0d",
                                  " got top=%h dd=%0d rd=%0d err=%0d"},
                                 s.top_value, s.data_depth, s.return_depth, s.error_code,
                                 got.top_value, got.data_depth, got.return_depth,
                                 got.error_code);
                end
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > 600000)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    task automatic wait_drained();
        while (pending_prims.size() != 0 || expected_status.size() != 0 || in_ch.valid)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic write_base(logic [5:0] v);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        m_base = v;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // random phase: mostly well-formed sequences, some noise
    task automatic random_phase(int unsigned count);
        int unsigned i, k, r, sim_d;
        logic [31:0] addr;
        sim_d = m_dcnt;
        i = 0;
        while (i < count)
        begin
            k = $urandom_range(0, 9);
            if (k < 3 && sim_d < DATA_DEPTH - 2)
            begin
                queue_prim(OP_LIT, rand_cell());
                queue_prim(OP_LIT, rand_cell());
                queue_prim(5'($urandom_range(OP_ADD, OP_EQ)), 0);
                sim_d++;
                i += 3;
            end
            else if (k == 3 && sim_d < DATA_DEPTH - 3)
            begin
                addr = ($urandom_range(0, 7) == 0) ? rand_cell() : $urandom_range(0, 15);
                queue_prim(OP_LIT, rand_cell());
                queue_prim(OP_LIT, addr);
                queue_prim(OP_STORE, $urandom);
                queue_prim(OP_LIT, addr);
                queue_prim(OP_FETCH, $urandom);
                if (addr >= MEM_WORDS) sim_d += 3;
                else sim_d += 1;
                i += 5;
            end
            else if (k == 4)
            begin
                queue_prim($urandom_range(0, 1) ? OP_TOR : OP_FROMR, $urandom);
                i++;
                sim_d = m_dcnt; // approximate; drift is harmless
            end
            else if (k == 5 && sim_d > 20)
            begin
                r = $urandom_range(5, 20);
                repeat (r) queue_prim(OP_DROP, $urandom);
                sim_d = (sim_d > 20) ? sim_d - 20 : 0;
                i += r;
            end
            else if (k == 6 && sim_d < DATA_DEPTH - 2)
            begin
                // fill far up to hit overflow now and then
                r = $urandom_range(1, 30);
                repeat (r) queue_prim($urandom_range(0, 1) ? OP_DEPTH : OP_DUP, $urandom);
                i += r;
            end
            else
            begin
                queue_prim(5'($urandom_range(0, 31)), $urandom);
                i++;
            end
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        m_base = 6'd10;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: underflows, extremes, special cases
        queue_prim(OP_ADD, 0);
        queue_prim(OP_DROP, 0);
        queue_prim(OP_FROMR, 0);
        queue_prim(OP_BASE, 0);
        queue_prim(OP_LIT, 32'h8000_0000);
        queue_prim(OP_LIT, 32'hFFFF_FFFF);
        queue_prim(OP_DIV, 0);
        queue_prim(OP_LIT, 32'h8000_0000);
        queue_prim(OP_LIT, 32'hFFFF_FFFF);
        queue_prim(OP_MOD, 0);
        queue_prim(OP_LIT, 0);
        queue_prim(OP_DIV, 0);
        queue_prim(OP_LIT, 32);
        queue_prim(OP_SHL, 0);
        queue_prim(OP_LIT, 32'h7FFF_FFFF);
        queue_prim(OP_LIT, 31);
        queue_prim(OP_SHR, 0);
        queue_prim(OP_DEPTH, 0);
        queue_prim(OP_LIT, MEM_WORDS);
        queue_prim(OP_FETCH, 0);
        queue_prim(OP_LIT, MEM_WORDS - 1);
        queue_prim(OP_STORE, 0);
        queue_prim(OP_SWAP, 0);
        queue_prim(OP_TOR, 0);
        queue_prim(5'd31, 0);
        wait_drained();

        write_base(6'd2);
        queue_prim(OP_BASE, 0);
        repeat (70) queue_prim(OP_DUP, 0);
        repeat (35) queue_prim(OP_TOR, 0);
        repeat (40) queue_prim(OP_FROMR, 0);
        wait_drained();
        random_phase(225);
        wait_drained();
        write_base(6'd36);
        queue_prim(OP_BASE, 0);
        random_phase(225);
        wait_drained();
        write_base(6'd63);
        queue_prim(OP_BASE, 0);
        wait_drained();
        write_base(6'd0);
        queue_prim(OP_BASE, 0);
        random_phase(225);
        wait_drained();

        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule
`default_nettype wire

// ===== sim.f =====
rtl/core/fsm_pkg.sv
rtl/core/fsm_if.sv
rtl/core/fsm_cell.sv
rtl/core/fsm_stack.sv
rtl/core/fsm_div.sv
rtl/core/forth_stack_machine_core.sv
dv/tb_top.sv
